>>> sv/ccc_pkg.sv
// ccc_pkg: item types, calendar constants and leap/month-length helpers
// for the calendar clock counter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [4:0] DAY_MIN   = 5'd1;
    localparam logic [3:0] MONTH_MIN = 4'd1;
    localparam logic [3:0] MONTH_MAX = 4'd12;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    localparam logic [4:0] LEN_LONG  = 5'd31;
    localparam logic [4:0] LEN_SHORT = 5'd30;
    localparam logic [4:0] LEN_FEB   = 5'd28;
    localparam logic [4:0] LEN_FEB_L = 5'd29;

    // y divisible by 25 iff (y * inverse of 25 mod 2^16) <= floor(65535 / 25)
    localparam logic [15:0] DIV25_INV = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [4:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
    } ccc_in_t;

    typedef struct packed {
        logic [5:0]  second_now;
        logic [5:0]  minute_now;
        logic [4:0]  hour_now;
        logic [4:0]  day_now;
        logic [3:0]  month_now;
        logic [15:0] year_now;
        logic        leap_now;
    } ccc_out_t;

    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        begin
            prod  = {16'd0, y} * {16'd0, DIV25_INV};
            div25 = (prod[15:0] <= DIV25_MAX);
            return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m) inside
                MONTH_FEB:                                  len = leap ? LEN_FEB_L : LEN_FEB;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
                default:                                    len = LEN_LONG;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/calendar_clock_counter_top.sv
// calendar_clock_counter_top: real-time clock and gregorian calendar with
// valid/ready item channels; depends on ccc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Each input item is a one-second tick or a load of a full date and time; each
// gives one result item with the date, time and leap flag after it. An item
// passes an input register, then the update logic that writes the result
// register, which is also the calendar state; one item can be taken every
// cycle while out_ready is high. The leap test of a new year (loaded, or the
// next year at new year's eve rollover) is one 16x16 multiply by the inverse
// of 25 plus a compare, and that path sets the cycle.
module calendar_clock_counter_top
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ccc_pkg::ccc_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ccc_pkg::ccc_out_t     out_data
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    ccc_pkg::ccc_in_t s1_data_reg;
    logic             s1_go;

    logic             out_valid_reg;
    logic             out_valid_next;

    logic [5:0]  sec_reg,   sec_next;
    logic [5:0]  min_reg,   min_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [4:0]  day_reg,   day_next;
    logic [3:0]  month_reg, month_next;
    logic [15:0] year_reg,  year_next;
    logic        leap_reg,  leap_next;

    logic [15:0] year_sel;
    logic        leap_sel;
    logic [3:0]  ld_month;
    logic [4:0]  ld_len;
    logic [4:0]  ld_day;
    logic [4:0]  cur_len;
    logic        sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // shared leap test: loaded year, or next year for a tick
    assign year_sel = (s1_data_reg.opcode == ccc_pkg::OP_LOAD) ?
                      s1_data_reg.load_year : year_reg + 16'd1;
    assign leap_sel = ccc_pkg::is_leap(year_sel);

    // load clamping
    always_comb
    begin
        ld_month = s1_data_reg.load_month;
        if (ld_month < ccc_pkg::MONTH_MIN)
        begin
            ld_month = ccc_pkg::MONTH_MIN;
        end
        else if (ld_month > ccc_pkg::MONTH_MAX)
        begin
            ld_month = ccc_pkg::MONTH_MAX;
        end
        ld_len = ccc_pkg::month_len(ld_month, leap_sel);
        ld_day = s1_data_reg.load_day;
        if (ld_day < ccc_pkg::DAY_MIN)
        begin
            ld_day = ccc_pkg::DAY_MIN;
        end
        else if (ld_day > ld_len)
        begin
            ld_day = ld_len;
        end
    end

    // tick cascade
    assign cur_len    = ccc_pkg::month_len(month_reg, leap_reg);
    assign sec_wrap   = (sec_reg == ccc_pkg::SEC_MAX);
    assign min_wrap   = sec_wrap && (min_reg == ccc_pkg::MIN_MAX);
    assign hour_wrap  = min_wrap && (hour_reg == ccc_pkg::HOUR_MAX);
    assign day_wrap   = hour_wrap && (day_reg >= cur_len);
    assign month_wrap = day_wrap && (month_reg == ccc_pkg::MONTH_MAX);

    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        leap_next  = leap_reg;
        if (s1_go)
        begin
            if (s1_data_reg.opcode == ccc_pkg::OP_LOAD)
            begin
                sec_next   = (s1_data_reg.load_second > ccc_pkg::SEC_MAX) ?
                             ccc_pkg::SEC_MAX : s1_data_reg.load_second;
                min_next   = (s1_data_reg.load_minute > ccc_pkg::MIN_MAX) ?
                             ccc_pkg::MIN_MAX : s1_data_reg.load_minute;
                hour_next  = (s1_data_reg.load_hour > ccc_pkg::HOUR_MAX) ?
                             ccc_pkg::HOUR_MAX : s1_data_reg.load_hour;
                day_next   = ld_day;
                month_next = ld_month;
                year_next  = s1_data_reg.load_year;
                leap_next  = leap_sel;
            end
            else
            begin
                sec_next = sec_wrap ? 6'd0 : sec_reg + 6'd1;
                if (sec_wrap)
                begin
                    min_next = min_wrap ? 6'd0 : min_reg + 6'd1;
                end
                if (min_wrap)
                begin
                    hour_next = hour_wrap ? 5'd0 : hour_reg + 5'd1;
                end
                if (hour_wrap)
                begin
                    day_next = day_wrap ? ccc_pkg::DAY_MIN : day_reg + 5'd1;
                end
                if (day_wrap)
                begin
                    month_next = month_wrap ? ccc_pkg::MONTH_MIN : month_reg + 4'd1;
                end
                if (month_wrap)
                begin
                    year_next = year_sel;
                    leap_next = leap_sel;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            day_reg       <= ccc_pkg::DAY_MIN;
            month_reg     <= ccc_pkg::MONTH_MIN;
            year_reg      <= 16'd0;
            leap_reg      <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            leap_reg      <= leap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.second_now = sec_reg;
    assign out_data.minute_now = min_reg;
    assign out_data.hour_now   = hour_reg;
    assign out_data.day_now    = day_reg;
    assign out_data.month_now  = month_reg;
    assign out_data.year_now   = year_reg;
    assign out_data.leap_now   = leap_reg;

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sec_reg <= ccc_pkg::SEC_MAX) && (min_reg <= ccc_pkg::MIN_MAX)
        && (hour_reg <= ccc_pkg::HOUR_MAX))
        else $error("time counter out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= ccc_pkg::MONTH_MIN) && (month_reg <= ccc_pkg::MONTH_MAX)
        && (day_reg >= ccc_pkg::DAY_MIN)
        && (day_reg <= ccc_pkg::month_len(month_reg, leap_reg)))
        else $error("date out of range");

    a_leap_match: assert property (@(posedge clk) disable iff (!rst_n)
        leap_reg == ccc_pkg::is_leap(year_reg))
        else $error("leap flag does not match year");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> out_valid_reg)
        else $error("item lost between stages");

endmodule

`default_nettype wire

>>> sim/calendar_clock_counter_checker.sv
// calendar_clock_counter_checker: watches both item channels of the calendar
// clock counter, predicts each result and compares it; depends on ccc_pkg
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_counter_checker
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire ccc_pkg::ccc_in_t in_data,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire ccc_pkg::ccc_out_t out_data,
    output int                    fail_count,
    output int                    open_count
);

    logic [5:0]  cal_sec;
    logic [5:0]  cal_min;
    logic [4:0]  cal_hour;
    logic [4:0]  cal_day;
    logic [3:0]  cal_month;
    logic [15:0] cal_year;

    ccc_pkg::ccc_out_t due_q[$];

    function automatic logic leap_year(input logic [15:0] y);
        int unsigned v;
        begin
            v = y;
            return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
        end
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [15:0] y);
        begin
            case (m)
                ccc_pkg::MONTH_FEB:
                    return leap_year(y) ? ccc_pkg::LEN_FEB_L : ccc_pkg::LEN_FEB;
                ccc_pkg::MONTH_APR, ccc_pkg::MONTH_JUN, ccc_pkg::MONTH_SEP,
                ccc_pkg::MONTH_NOV:
                    return ccc_pkg::LEN_SHORT;
                default:
                    return ccc_pkg::LEN_LONG;
            endcase
        end
    endfunction

    // updates the calendar state and returns the date and time after the item
    function automatic ccc_pkg::ccc_out_t next_calendar(input ccc_pkg::ccc_in_t item);
        ccc_pkg::ccc_out_t r;
        logic [3:0]        m;
        logic [4:0]        d;
        logic [4:0]        len;
        begin
            if (item.opcode == ccc_pkg::OP_LOAD)
            begin
                m = item.load_month;
                if (m < ccc_pkg::MONTH_MIN) m = ccc_pkg::MONTH_MIN;
                if (m > ccc_pkg::MONTH_MAX) m = ccc_pkg::MONTH_MAX;
                len = days_in(m, item.load_year);
                d = item.load_day;
                if (d < ccc_pkg::DAY_MIN) d = ccc_pkg::DAY_MIN;
                if (d > len) d = len;
                cal_sec   = (item.load_second > ccc_pkg::SEC_MAX) ?
                            ccc_pkg::SEC_MAX : item.load_second;
                cal_min   = (item.load_minute > ccc_pkg::MIN_MAX) ?
                            ccc_pkg::MIN_MAX : item.load_minute;
                cal_hour  = (item.load_hour > ccc_pkg::HOUR_MAX) ?
                            ccc_pkg::HOUR_MAX : item.load_hour;
                cal_day   = d;
                cal_month = m;
                cal_year  = item.load_year;
            end
            else if (cal_sec != ccc_pkg::SEC_MAX)
            begin
                cal_sec = cal_sec + 6'd1;
            end
            else
            begin
                cal_sec = '0;
                if (cal_min != ccc_pkg::MIN_MAX)
                begin
                    cal_min = cal_min + 6'd1;
                end
                else
                begin
                    cal_min = '0;
                    if (cal_hour != ccc_pkg::HOUR_MAX)
                    begin
                        cal_hour = cal_hour + 5'd1;
                    end
                    else
                    begin
                        cal_hour = '0;
                        if (cal_day < days_in(cal_month, cal_year))
                        begin
                            cal_day = cal_day + 5'd1;
                        end
                        else
                        begin
                            cal_day = ccc_pkg::DAY_MIN;
                            if (cal_month != ccc_pkg::MONTH_MAX)
                            begin
                                cal_month = cal_month + 4'd1;
                            end
                            else
                            begin
                                cal_month = ccc_pkg::MONTH_MIN;
                                cal_year  = cal_year + 16'd1;
                            end
                        end
                    end
                end
            end
            r.second_now = cal_sec;
            r.minute_now = cal_min;
            r.hour_now   = cal_hour;
            r.day_now    = cal_day;
            r.month_now  = cal_month;
            r.year_now   = cal_year;
            r.leap_now   = leap_year(cal_year);
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ccc_pkg::ccc_out_t want;
        if (!rst_n)
        begin
            cal_sec   = '0;
            cal_min   = '0;
            cal_hour  = '0;
            cal_day   = ccc_pkg::DAY_MIN;
            cal_month = ccc_pkg::MONTH_MIN;
            cal_year  = '0;
            due_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("%0t: result item with nothing expected", $realtime);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (out_data.second_now !== want.second_now
                        || out_data.minute_now !== want.minute_now
                        || out_data.hour_now !== want.hour_now
                        || out_data.day_now !== want.day_now
                        || out_data.month_now !== want.month_now
                        || out_data.year_now !== want.year_now
                        || out_data.leap_now !== want.leap_now)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display({"%0t: exp %0d:%0d:%0d %0d/%0d/%0d leap %0b, ",
                                      "got %0d:%0d:%0d %0d/%0d/%0d leap %0b"},
                                $realtime, want.hour_now, want.minute_now, want.second_now,
                                want.day_now, want.month_now, want.year_now, want.leap_now,
                                out_data.hour_now, out_data.minute_now, out_data.second_now,
                                out_data.day_now, out_data.month_now, out_data.year_now,
                                out_data.leap_now);
                    end
                end
            end
            if (in_valid && in_ready)
                due_q.push_back(next_calendar(in_data));
        end
        open_count = due_q.size();
    end

endmodule

`default_nettype wire

>>> sim/calendar_clock_counter_top_test.sv
// calendar_clock_counter_top_test: drives ticks and date/time loads into the
// calendar clock counter and gives the verdict; depends on ccc_pkg,
// calendar_clock_counter_top and calendar_clock_counter_checker
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_counter_top_test;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    ccc_pkg::ccc_in_t  in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    ccc_pkg::ccc_out_t out_data;
    int                fail_count;
    int                open_count;
    int                n_sent = 0;
    logic              steady = 1'b0;

    calendar_clock_counter_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    calendar_clock_counter_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input ccc_pkg::ccc_in_t item);
        begin
            while (!steady && $urandom_range(99) < 34)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do
                @(posedge clk);
            while (!in_ready);
            n_sent = n_sent + 1;
            @(negedge clk);
        end
    endtask

    function automatic ccc_pkg::ccc_in_t tick_item();
        ccc_pkg::ccc_in_t it;
        logic [63:0]      raw;
        begin
            raw = {$urandom, $urandom};
            it = raw[$bits(ccc_pkg::ccc_in_t)-1:0];
            it.opcode = ccc_pkg::OP_TICK;
            return it;
        end
    endfunction

    function automatic ccc_pkg::ccc_in_t load_item(input int s, input int mi, input int h,
                                                   input int d, input int mo, input int y);
        ccc_pkg::ccc_in_t it;
        begin
            it.opcode      = ccc_pkg::OP_LOAD;
            it.load_second = 6'(s);
            it.load_minute = 6'(mi);
            it.load_hour   = 5'(h);
            it.load_day    = 5'(d);
            it.load_month  = 4'(mo);
            it.load_year   = 16'(y);
            return it;
        end
    endfunction

    // a load just before a carry, mostly near the end of a day and a month
    function automatic ccc_pkg::ccc_in_t near_carry_load();
        int y;
        begin
            case ($urandom_range(4))
                0: y = 400 * $urandom_range(163);
                1: y = 100 * $urandom_range(655);
                2: y = 4 * $urandom_range(16383);
                3: y = ($urandom_range(1) == 1) ? 65535 : 65532;
                default: y = $urandom_range(65535);
            endcase
            return load_item($urandom_range(48, 63),
                             ($urandom_range(3) == 0) ? $urandom_range(63) : 59,
                             ($urandom_range(3) == 0) ? $urandom_range(31) : 23,
                             ($urandom_range(3) == 0) ? $urandom_range(31)
                                                      : $urandom_range(27, 31),
                             ($urandom_range(3) == 0) ? $urandom_range(15)
                                                      : $urandom_range(1, 12),
                             y);
        end
    endfunction

    initial
    begin
        int burst;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(tick_item());
        send_item(load_item(63, 63, 31, 31, 15, 65535));
        send_item(tick_item());
        send_item(load_item(0, 0, 0, 0, 0, 0));
        send_item(tick_item());
        send_item(load_item(59, 59, 23, 29, 2, 2024));
        send_item(tick_item());
        send_item(load_item(59, 59, 23, 31, 2, 2023));
        send_item(tick_item());
        send_item(load_item(10, 20, 5, 30, 2, 1900));
        send_item(load_item(59, 59, 23, 30, 2, 2000));
        send_item(tick_item());
        send_item(load_item(59, 59, 23, 31, 4, 2021));
        send_item(tick_item());
        send_item(load_item(59, 59, 23, 31, 12, 2023));
        send_item(tick_item());
        send_item(load_item(59, 0, 12, 15, 7, 1999));
        send_item(tick_item());
        send_item(load_item(59, 59, 12, 15, 7, 1999));
        send_item(tick_item());
        send_item(load_item(30, 30, 10, 0, 13, 100));
        send_item(load_item(59, 59, 23, 30, 9, 400));
        send_item(tick_item());

        while (n_sent < 1650)
        begin
            steady <= (n_sent >= 700 && n_sent < 950);
            if ($urandom_range(99) < 30)
            begin
                send_item(load_item($urandom_range(63), $urandom_range(63),
                                    $urandom_range(31), $urandom_range(31),
                                    $urandom_range(15), $urandom_range(65535)));
                burst = $urandom_range(3);
            end
            else
            begin
                send_item(near_carry_load());
                burst = $urandom_range(1, 15);
            end
            repeat (burst) send_item(tick_item());
        end

        in_valid <= 1'b0;
        while (open_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
